FILE: src/lfu_pkg.sv
// Shared constants, codes and types of the frequency-ordered cache table.
package lfu_pkg;

  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_COUNT_BITS = 16;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] NO_KEY     = 32'h0000_0000;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  // Verdict of the compare unit on one stored entry.
  typedef struct packed {
    logic key_match;
    logic beats_victim;
  } pick_t;

endpackage

FILE: src/lfu_pick.sv
// Compare unit: judges one stored entry against the request key and the victim so far.
module lfu_pick #(
  parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS,
  parameter int RANK_W     = 4
) (
  input  logic [lfu_pkg::DATA_W-1:0] req_key,
  input  logic [lfu_pkg::DATA_W-1:0] entry_key,
  input  logic [COUNT_BITS-1:0]      entry_count,
  input  logic [RANK_W-1:0]          entry_rank,
  input  logic                       have_victim,
  input  logic [COUNT_BITS-1:0]      victim_count,
  input  logic [RANK_W-1:0]          victim_rank,
  output lfu_pkg::pick_t             verdict
);
  import lfu_pkg::*;

  // Lower count wins; among equal counts the older entry (larger rank) wins.
  always_comb begin
    verdict.key_match    = (entry_key == req_key);
    verdict.beats_victim = !have_victim
                           || (entry_count < victim_count)
                           || ((entry_count == victim_count) && (entry_rank > victim_rank));
  end

endmodule

FILE: src/lfu_cache_table.sv
// Top level of the frequency-ordered key/value cache table.
//
// A fully associative cache of ENTRIES key/value pairs that evicts the least
// frequently used entry, and the least recently used one among equal counts.
// Every request beat (get or put) gives exactly one result beat. A request is
// handled one at a time: a scan sweeps the entry memory one entry per cycle
// through its single read port, feeding a shared compare unit that finds the
// key match, counts occupancy, picks the victim and the lowest free slot. A
// hit or a put that changes the table is then followed by a second sweep of
// the same port that rewrites the recency ranks and the touched entry. A get
// that misses is answered after the scan alone, and any request with a
// capacity of zero is answered without a sweep. The request channel opens
// again in the cycle after the result is staged. A finished result sits in
// an output register, so the next request beat is taken while it waits. The
// capacity register is written through its own channel whenever the block is
// idle; a pending capacity beat holds off the request channel, so a write
// and a request offered together take effect in that order. Values above
// ENTRIES act as ENTRIES, and zero turns the cache off.
module lfu_cache_table #(
  parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
  parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // Request channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic signed [lfu_pkg::DATA_W-1:0] key,
  input  logic signed [lfu_pkg::DATA_W-1:0] put_value,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              hit,
  output logic signed [lfu_pkg::DATA_W-1:0] read_value,
  output logic                              evicted,
  output logic signed [lfu_pkg::DATA_W-1:0] evicted_key,
  // Capacity register write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lfu_pkg::CAP_W-1:0]         cfg_data
);
  import lfu_pkg::*;

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IDX_W  = RANK_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CNT_W-1:0]      N_ENT     = CNT_W'(ENTRIES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  typedef struct packed {
    logic [DATA_W-1:0]     key;
    logic [DATA_W-1:0]     data;
    logic [COUNT_BITS-1:0] count;
    logic [RANK_W-1:0]     rank;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPDATE,
    S_RESP
  } state_t;

  state_t state;

  // Capacity register.
  logic [CAP_W-1:0] cap_reg;

  // Entry storage: valid bits in flops, everything else in one memory.
  logic [ENTRIES-1:0] valid;
  entry_t             mem [ENTRIES];
  entry_t             rd_q;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  entry_t             wr_ent;

  // Latched request.
  logic              req_kind;
  logic [DATA_W-1:0] req_key;
  logic [DATA_W-1:0] req_val;

  // Sweep control: cnt issues addresses, pend marks read data arriving.
  logic [CNT_W-1:0] cnt;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;

  // Scan findings.
  logic [CNT_W-1:0] used;
  logic             found;
  logic [IDX_W-1:0] found_idx;
  entry_t           found_ent;
  logic             have_vic;
  logic [IDX_W-1:0] vic_idx;
  entry_t           vic_ent;
  logic             have_free;
  logic [IDX_W-1:0] free_idx;

  // Update plan for the rewrite sweep.
  logic [IDX_W-1:0]  target;
  entry_t            new_ent;
  logic [RANK_W-1:0] thr;
  logic              fill_all;

  // Staged result.
  logic              res_hit;
  logic [DATA_W-1:0] res_rd;
  logic              res_ev;
  logic [DATA_W-1:0] res_evk;

  pick_t                 pk;
  logic                  full;
  logic [COUNT_BITS-1:0] hit_count;
  logic [RANK_W-1:0]     rank_inc;

  assign in_stall  = rst || (state != S_IDLE) || cfg_valid;
  assign cfg_ready = !rst && (state == S_IDLE);
  assign rd_addr   = cnt[IDX_W-1:0];
  assign mem_we    = (state == S_UPDATE) && pend;

  // The table counts as full when occupancy reaches the capacity or the
  // physical size, which also covers capacities above ENTRIES.
  assign full = (CMP_W'(used) >= CMP_W'(cap_reg)) || (used == N_ENT);

  assign hit_count = (found_ent.count == COUNT_MAX) ? found_ent.count
                                                    : found_ent.count + COUNT_ONE;
  assign rank_inc  = rd_q.rank + RANK_W'(1);

  lfu_pick #(
    .COUNT_BITS (COUNT_BITS),
    .RANK_W     (RANK_W)
  ) u_pick (
    .req_key      (req_key),
    .entry_key    (rd_q.key),
    .entry_count  (rd_q.count),
    .entry_rank   (rd_q.rank),
    .have_victim  (have_vic),
    .victim_count (vic_ent.count),
    .victim_rank  (vic_ent.rank),
    .verdict      (pk)
  );

  // During the rewrite sweep the target gets its new contents; every other
  // valid entry younger than the threshold (or all of them on a plain fill)
  // ages by one rank.
  always_comb begin
    wr_ent = rd_q;
    if (pend_idx == target) begin
      wr_ent = new_ent;
    end else if (valid[pend_idx] && (fill_all || (rd_q.rank < thr))) begin
      wr_ent.rank = rank_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pend_idx] <= wr_ent;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cap_reg   <= CAP_RESET;
      valid     <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
      pend      <= 1'b0;
      found     <= 1'b0;
      have_vic  <= 1'b0;
      have_free <= 1'b0;
      used      <= '0;
    end else begin
      // In S_RESP the output register is handled by the state itself.
      if (out_valid && !out_stall && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        cap_reg <= cfg_data;
      end

      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req_kind  <= kind;
            req_key   <= key;
            req_val   <= put_value;
            res_hit   <= 1'b0;
            res_rd    <= MISS_VALUE;
            res_ev    <= 1'b0;
            res_evk   <= NO_KEY;
            cnt       <= '0;
            pend      <= 1'b0;
            found     <= 1'b0;
            have_vic  <= 1'b0;
            have_free <= 1'b0;
            used      <= '0;
            state     <= (cap_reg == '0) ? S_RESP : S_SCAN;
          end
        end

        S_SCAN: begin
          if (cnt < N_ENT) begin
            cnt <= cnt + CNT_W'(1);
          end
          pend     <= (cnt < N_ENT);
          pend_idx <= cnt[IDX_W-1:0];
          if (pend) begin
            if (valid[pend_idx]) begin
              used <= used + CNT_W'(1);
              if (!found && pk.key_match) begin
                found     <= 1'b1;
                found_idx <= pend_idx;
                found_ent <= rd_q;
              end
              if (pk.beats_victim) begin
                have_vic <= 1'b1;
                vic_idx  <= pend_idx;
                vic_ent  <= rd_q;
              end
            end else if (!have_free) begin
              have_free <= 1'b1;
              free_idx  <= pend_idx;
            end
          end
          if ((cnt == N_ENT) && !pend) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          cnt  <= '0;
          pend <= 1'b0;
          if (found) begin
            res_hit <= 1'b1;
            if (req_kind == KIND_GET) begin
              res_rd <= found_ent.data;
            end
            target        <= found_idx;
            new_ent.key   <= found_ent.key;
            new_ent.data  <= (req_kind == KIND_PUT) ? req_val : found_ent.data;
            new_ent.count <= hit_count;
            new_ent.rank  <= '0;
            thr           <= found_ent.rank;
            fill_all      <= 1'b0;
            state         <= S_UPDATE;
          end else if (req_kind == KIND_PUT) begin
            new_ent.key   <= req_key;
            new_ent.data  <= req_val;
            new_ent.count <= COUNT_ONE;
            new_ent.rank  <= '0;
            if (full) begin
              // Reuse the victim's slot; entries older than it keep rank.
              res_ev   <= 1'b1;
              res_evk  <= vic_ent.key;
              target   <= vic_idx;
              thr      <= vic_ent.rank;
              fill_all <= 1'b0;
            end else begin
              target          <= free_idx;
              valid[free_idx] <= 1'b1;
              thr             <= '0;
              fill_all        <= 1'b1;
            end
            state <= S_UPDATE;
          end else begin
            state <= S_RESP;
          end
        end

        S_UPDATE: begin
          if (cnt < N_ENT) begin
            cnt <= cnt + CNT_W'(1);
          end
          pend     <= (cnt < N_ENT);
          pend_idx <= cnt[IDX_W-1:0];
          if ((cnt == N_ENT) && !pend) begin
            state <= S_RESP;
          end
        end

        S_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            hit         <= res_hit;
            read_value  <= res_rd;
            evicted     <= res_ev;
            evicted_key <= res_evk;
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A request beat closes the request channel until its result is staged.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while a request was in flight");

  // A result never both hits and evicts.
  a_hit_evict_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted))
    else $error("result reports a hit and an eviction");

  // An eviction only comes from a put, whose read value is the miss value.
  a_evict_is_put: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> read_value == MISS_VALUE)
    else $error("eviction with a read value");

  // A put that misses into a table with room must have found a free slot.
  a_free_slot: assert property (@(posedge clk) disable iff (rst)
    state == S_DECIDE && !found && req_kind == KIND_PUT && !full |-> have_free)
    else $error("no free slot although the table is not full");

  // Occupancy never exceeds the physical size.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DECIDE |-> used <= N_ENT)
    else $error("occupancy count out of range");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the frequency-ordered key/value cache table.
module tb_top;
  import lfu_pkg::*;

  localparam int ENTRIES    = DEF_ENTRIES;
  localparam int COUNT_BITS = DEF_COUNT_BITS;
  // Longest request is two sweeps of the entry memory plus its decide and result steps.
  localparam int QUIET_CYCLES = 2 * ENTRIES + 40;
  localparam int IDLE_PERCENT = 38;

  // One request beat as the sender holds it.
  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] put_value;
  } request_t;

  // One result beat as the cache should return it.
  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [DATA_W-1:0] evicted_key;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic                     kind      = KIND_GET;
  logic signed [DATA_W-1:0] key       = '0;
  logic signed [DATA_W-1:0] put_value = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     hit;
  logic signed [DATA_W-1:0] read_value;
  logic                     evicted;
  logic signed [DATA_W-1:0] evicted_key;

  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data  = '0;

  // Requests waiting to be offered, and replies waiting to come back.
  request_t pending_requests[$];
  reply_t   awaited_replies[$];
  request_t offered;

  // When calm is set, neither side inserts bubbles or stalls.
  logic calm = 1'b0;
  int   mismatch_count = 0;

  // Shadow copy of the cache table, kept in step with every accepted beat.
  logic [CAP_W-1:0]      shadow_cap;
  logic                  shadow_live [ENTRIES];
  logic [DATA_W-1:0]     shadow_key  [ENTRIES];
  logic [DATA_W-1:0]     shadow_data [ENTRIES];
  logic [COUNT_BITS-1:0] shadow_uses [ENTRIES];
  int                    shadow_age  [ENTRIES];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lfu_cache_table u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .key         (key),
    .put_value   (put_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  // Applies one request to the shadow table and returns the reply it earns.
  // Age 0 is the most recent live entry; ages among live entries stay dense.
  function automatic reply_t serve_request(request_t rq);
    reply_t reply;
    int     cap;
    int     found;
    int     used;
    int     slot;
    int     old_age;
    reply.hit         = 1'b0;
    reply.read_value  = MISS_VALUE;
    reply.evicted     = 1'b0;
    reply.evicted_key = NO_KEY;
    cap = (shadow_cap > ENTRIES) ? ENTRIES : int'(shadow_cap);
    // A capacity of zero turns the cache off: nothing hits, nothing changes.
    if (cap == 0)
      return reply;
    found = -1;
    used  = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_live[i]) begin
        used++;
        if (found < 0 && shadow_key[i] == rq.key)
          found = i;
      end
    end
    if (found >= 0) begin
      reply.hit = 1'b1;
      if (rq.kind == KIND_PUT)
        shadow_data[found] = rq.put_value;
      else
        reply.read_value = shadow_data[found];
      // The use count sticks at its top value once there.
      if (shadow_uses[found] != '1)
        shadow_uses[found]++;
      old_age = shadow_age[found];
      for (int i = 0; i < ENTRIES; i++)
        if (shadow_live[i] && i != found && shadow_age[i] < old_age)
          shadow_age[i]++;
      shadow_age[found] = 0;
    end else if (rq.kind == KIND_PUT) begin
      slot = -1;
      // A full table (or one over a lowered capacity) gives up one victim:
      // the lowest count, and the oldest among equal counts.
      if (used >= cap) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (shadow_live[i] && (slot < 0 || shadow_uses[i] < shadow_uses[slot] ||
              (shadow_uses[i] == shadow_uses[slot] && shadow_age[i] > shadow_age[slot])))
            slot = i;
        end
        if (slot >= 0) begin
          old_age           = shadow_age[slot];
          reply.evicted     = 1'b1;
          reply.evicted_key = shadow_key[slot];
          shadow_live[slot] = 1'b0;
          for (int i = 0; i < ENTRIES; i++)
            if (shadow_live[i] && shadow_age[i] > old_age)
              shadow_age[i]--;
        end
      end
      if (slot < 0) begin
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (!shadow_live[i])
            slot = i;
      end
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (shadow_live[i])
            shadow_age[i]++;
        shadow_live[slot] = 1'b1;
        shadow_key[slot]  = rq.key;
        shadow_data[slot] = rq.put_value;
        shadow_uses[slot] = COUNT_BITS'(1);
        shadow_age[slot]  = 0;
      end
    end
    return reply;
  endfunction

  // Request driver. A beat stays on the port, unchanged, until it is taken.
  // The shadow table is updated at the very edge that takes the beat, so the
  // expected reply always reflects the order in which the cache saw requests.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        awaited_replies = {awaited_replies, serve_request(offered)};
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 &&
            (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          offered = pending_requests.pop_front();
          in_valid  <= 1'b1;
          kind      <= offered.kind;
          key       <= offered.key;
          put_value <= offered.put_value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each beat taken is matched against the oldest expected
  // reply, field by field; the stall is redrawn every cycle.
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: result beat with no request outstanding", $time);
          mismatch_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (hit !== want.hit) begin
            $display("%0t: hit expected %b actual %b", $time, want.hit, hit);
            mismatch_count++;
          end
          if (read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h", $time,
                     want.read_value, read_value);
            mismatch_count++;
          end
          if (evicted !== want.evicted) begin
            $display("%0t: evicted expected %b actual %b", $time, want.evicted, evicted);
            mismatch_count++;
          end
          if (evicted_key !== want.evicted_key) begin
            $display("%0t: evicted_key expected %h actual %h", $time,
                     want.evicted_key, evicted_key);
            mismatch_count++;
          end
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  task automatic queue_request(input logic k, input logic [DATA_W-1:0] kv,
                               input logic [DATA_W-1:0] pv);
    request_t rq;
    rq.kind      = k;
    rq.key       = kv;
    rq.put_value = pv;
    pending_requests = {pending_requests, rq};
  endtask

  // Holds off until every queued request has been answered and the cache
  // has had time to settle. Returns on a falling edge.
  task automatic wait_drained();
    do
      @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || awaited_replies.size() != 0);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // Writes the capacity register while the cache is idle. Returns on a
  // falling edge so that the caller can queue requests without a race.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid  <= 1'b0;
    shadow_cap = value;
    @(negedge clk);
  endtask

  // One stretch of random traffic. Most keys come from a small pool, drawn
  // with a bias toward its first entries so that use counts spread apart and
  // both hits and evictions are frequent; a few requests use fresh keys.
  task automatic random_phase(input int n_items, input int pool_n);
    logic [DATA_W-1:0] pool[$];
    logic [DATA_W-1:0] k;
    logic              op;
    pool.delete();
    for (int j = 0; j < pool_n; j++) begin
      case ($urandom_range(0, 9))
        0:       pool = {pool, DATA_W'(32'h8000_0000 + j)};
        1:       pool = {pool, DATA_W'(32'h7FFF_FFFF - j)};
        default: pool = {pool, DATA_W'($urandom())};
      endcase
    end
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 99) < 8) begin
        k  = $urandom();
        op = 1'($urandom_range(0, 1));
      end else begin
        k  = pool[$urandom_range(0, $urandom_range(0, pool_n - 1))];
        op = ($urandom_range(0, 99) < 55) ? KIND_PUT : KIND_GET;
      end
      queue_request(op, k, $urandom());
    end
    wait_drained();
  endtask

  initial begin
    logic [CAP_W-1:0] caps[10];
    int               counts[10];
    caps   = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd8, 5'd2, 5'd16, 5'd12, 5'd3};
    counts = '{80, 50, 60, 15, 80, 60, 50, 80, 70, 60};

    shadow_cap = CAP_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_live[i] = 1'b0;
      shadow_key[i]  = '0;
      shadow_data[i] = '0;
      shadow_uses[i] = '0;
      shadow_age[i]  = 0;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Basic gets and puts at the reset capacity, with the extreme keys and
    // values: a miss on an empty table, inserts, a read hit, an overwrite.
    queue_request(KIND_GET, 32'h0000_0000, 32'h1234_5678);
    queue_request(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_request(KIND_PUT, 32'h0000_0000, 32'h0000_0000);
    queue_request(KIND_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_request(KIND_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_request(KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_request(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    wait_drained();

    // Capacity lowered below the occupancy: each missing put evicts one
    // entry. The second eviction removes the newcomer with the lowest count,
    // and the third breaks a tie in count by taking the older entry.
    write_capacity(5'd2);
    queue_request(KIND_PUT, 32'h0000_0005, 32'hAAAA_5555);
    queue_request(KIND_PUT, 32'h0000_0006, 32'h5555_AAAA);
    queue_request(KIND_GET, 32'h0000_0006, 32'h0000_0000);
    queue_request(KIND_PUT, 32'h0000_0007, 32'h0F0F_F0F0);
    wait_drained();

    // A zero capacity turns the cache off, even for keys that are stored.
    write_capacity(5'd0);
    queue_request(KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_request(KIND_PUT, 32'h0000_0009, 32'h0000_0001);
    wait_drained();

    // A capacity above the table size acts as the full table.
    write_capacity(5'd31);
    queue_request(KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_request(KIND_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
    wait_drained();

    // Random traffic across a range of capacities. The table contents carry
    // over from one setting to the next, and one stretch runs without any
    // bubbles or stalls on either side.
    for (int p = 0; p < 10; p++) begin
      write_capacity(caps[p]);
      calm = (p == 7);
      random_phase(counts[p], int'(caps[p] > ENTRIES ? ENTRIES : caps[p]) +
                   $urandom_range(2, 8));
      calm = 1'b0;
    end

    if (mismatch_count == 0 && awaited_replies.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
